>>> rtl/assert_macros.svh
// Assertion helpers for the matrix inverse block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MI3_ASSERT_IMP(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// next-cycle implication
`define MI3_ASSERT_NXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

>>> rtl/mi3_pkg.sv
// ---------------------------------------------------------------------------
// mi3_pkg
// Types, cofactor index table and saturation helper for the 3x3 inverse.
// ---------------------------------------------------------------------------
`default_nettype none
package mi3_pkg;

  localparam int NL   = 9;   // matrix entries / result lanes
  localparam int DW   = 97;  // exact determinant width
  localparam int CW   = 65;  // exact cofactor width
  localparam int RW   = 98;  // division remainder width
  localparam int QW   = 32;  // quotient bits kept
  localparam int NDIV = 32;  // division steps

  // cofactor i = m[x]*m[y] - m[u]*m[v]
  localparam int CF_IDX [NL][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic                    sing;
    word_t                   det_out;
    logic [DW-1:0]           d;
    logic [NL-1:0]           neg;
    logic [NL-1:0]           over;
    logic [NL-1:0][RW-1:0]   rem;
    logic [NL-1:0][QW-1:0]   q;
  } div_t;

  // magnitude (over = at least 2^32) with sign to Q16.16 pattern
  function automatic word_t sat32(logic over, logic [31:0] q, logic neg);
    word_t r;
    if (!neg) begin
      r = (over || q[31]) ? word_t'(32'h7FFF_FFFF) : word_t'(q);
    end else begin
      r = (over || q > 32'h8000_0000) ? word_t'(32'h8000_0000) : word_t'(-q);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mi3_in_if.sv
// ---------------------------------------------------------------------------
// mi3_in_if
// Input channel: one row-major 3x3 Q16.16 matrix per item.
// ---------------------------------------------------------------------------
`default_nettype none
interface mi3_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/mi3_out_if.sv
// ---------------------------------------------------------------------------
// mi3_out_if
// Result channel: inverse, determinant and singular flag per item.
// ---------------------------------------------------------------------------
`default_nettype none
interface mi3_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [31:0] det_out;
  logic singular;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  det_out, singular, input ready);
  modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  det_out, singular, output ready);
endinterface
`default_nettype wire

>>> rtl/mi3_front.sv
// ---------------------------------------------------------------------------
// mi3_front
// Six stages: capture, cofactor products, cofactors, determinant partial
// products, determinant sum, magnitudes and divider setup.
// ---------------------------------------------------------------------------
`default_nettype none
module mi3_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire logic                in_v,
  input  wire mi3_pkg::word_t      mat [mi3_pkg::NL],
  output logic                     out_v,
  output mi3_pkg::div_t            out_st
);
  import mi3_pkg::*;

  logic [5:0] v_r;

  word_t                m1_r [NL];
  logic signed [63:0]   p_r  [2*NL];
  word_t                m2_r [3];
  logic signed [CW-1:0] c_r  [NL];
  word_t                m3_r [3];
  logic signed [CW-1:0] plo_r [3];
  logic signed [CW-1:0] phi_r [3];
  logic signed [CW-1:0] c4_r [NL];
  logic signed [DW-1:0] det_r;
  logic signed [CW-1:0] c5_r [NL];
  div_t                 st_r;

  logic [DW-1:0]        dmag;
  logic [DW-1:0]        dsh;
  logic [CW-1:0]        cm [NL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        m1_r[i]     <= mat[i];
        p_r[2*i]    <= m1_r[CF_IDX[i][0]] * m1_r[CF_IDX[i][1]];
        p_r[2*i+1]  <= m1_r[CF_IDX[i][2]] * m1_r[CF_IDX[i][3]];
        c_r[i]      <= CW'(p_r[2*i]) - CW'(p_r[2*i+1]);
        c4_r[i]     <= c_r[i];
        c5_r[i]     <= c4_r[i];
      end
      for (int k = 0; k < 3; k++) begin
        m2_r[k]  <= m1_r[k];
        m3_r[k]  <= m2_r[k];
        // expansion along row 0 uses cofactors 0, 3, 6; split 65 bits as 32 + 33
        plo_r[k] <= m3_r[k] * $signed({1'b0, c_r[3*k][31:0]});
        phi_r[k] <= m3_r[k] * $signed(c_r[3*k][CW-1:32]);
      end
      det_r <= DW'(plo_r[0]) + DW'(plo_r[1]) + DW'(plo_r[2])
             + ((DW'(phi_r[0]) + DW'(phi_r[1]) + DW'(phi_r[2])) <<< 32);
      st_r  <= out_nxt();
    end
  end

  assign dmag = det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
  assign dsh  = dmag >> 32;

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      cm[i] = c5_r[i][CW-1] ? CW'(-c5_r[i]) : CW'(c5_r[i]);
    end
  end

  function automatic div_t out_nxt();
    div_t s;
    s.sing    = (dmag == '0);
    s.det_out = sat32(|dsh[64:32], dsh[31:0], det_r[DW-1]);
    s.d       = dmag;
    for (int i = 0; i < NL; i++) begin
      s.neg[i]  = c5_r[i][CW-1] ^ det_r[DW-1];
      // quotient reaches 2^32 exactly when |c| >= |det|
      s.over[i] = {32'b0, cm[i]} >= dmag;
      s.rem[i]  = RW'(cm[i]);
      s.q[i]    = '0;
    end
    return s;
  endfunction

  assign out_v  = v_r[5];
  assign out_st = st_r;

endmodule
`default_nettype wire

>>> rtl/mi3_div_stage.sv
// ---------------------------------------------------------------------------
// mi3_div_stage
// One restoring division step for all nine lanes, registered.
// ---------------------------------------------------------------------------
`default_nettype none
module mi3_div_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_v,
  input  wire mi3_pkg::div_t   in_st,
  output logic                 out_v,
  output mi3_pkg::div_t        out_st
);
  import mi3_pkg::*;

  logic  v_r;
  div_t  st_r;
  div_t  st_nxt;
  logic [RW-1:0] r2 [NL];
  logic [NL-1:0] ge;

  always_comb begin
    st_nxt = in_st;
    for (int i = 0; i < NL; i++) begin
      r2[i] = {in_st.rem[i][RW-2:0], 1'b0};
      ge[i] = r2[i] >= {1'b0, in_st.d};
      st_nxt.rem[i] = ge[i] ? r2[i] - {1'b0, in_st.d} : r2[i];
      st_nxt.q[i]   = {in_st.q[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= st_nxt;
    end
  end

  assign out_v  = v_r;
  assign out_st = st_r;

endmodule
`default_nettype wire

>>> rtl/matrix_inverse_3x3.sv
// ---------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined exact 3x3 inverse by adjugate over determinant, Q16.16.
// ---------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | a00..a22, signed Q16.16
//  out_ch  | out | r00..r22, det_out (Q16.16), singular
//
//  One item per cycle while out_ch does not stall: 6 front stages, 32 division
//  stages (one quotient bit each, nine lanes), one saturating output register.
//  The whole pipe advances together whenever the output register is free.
//  A stall at out_ch holds every stage; in_ch.ready drops in the same cycle.
//  Reset clears only the valid bits.
`default_nettype none
module matrix_inverse_3x3 (
  input  wire logic  clk,
  input  wire logic  rst_n,
  mi3_in_if.sink     in_ch,
  mi3_out_if.source  out_ch
);
  import mi3_pkg::*;

  logic   adv;
  word_t  mat [NL];
  logic   v   [NDIV+1];
  div_t   st  [NDIV+1];
  logic   out_v_r;
  word_t  r_r [NL];
  word_t  det_r;
  logic   sing_r;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign mat[0] = in_ch.a00;
  assign mat[1] = in_ch.a01;
  assign mat[2] = in_ch.a02;
  assign mat[3] = in_ch.a10;
  assign mat[4] = in_ch.a11;
  assign mat[5] = in_ch.a12;
  assign mat[6] = in_ch.a20;
  assign mat[7] = in_ch.a21;
  assign mat[8] = in_ch.a22;

  mi3_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(in_ch.valid), .mat(mat),
    .out_v(v[0]), .out_st(st[0])
  );

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    mi3_div_stage u_stage (
      .clk(clk), .rst_n(rst_n), .adv(adv), .in_v(v[g]), .in_st(st[g]),
      .out_v(v[g+1]), .out_st(st[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= v[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        r_r[i] <= st[NDIV].sing ? '0
                : sat32(st[NDIV].over[i], st[NDIV].q[i], st[NDIV].neg[i]);
      end
      det_r  <= st[NDIV].det_out;
      sing_r <= st[NDIV].sing;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.r00      = r_r[0];
  assign out_ch.r01      = r_r[1];
  assign out_ch.r02      = r_r[2];
  assign out_ch.r10      = r_r[3];
  assign out_ch.r11      = r_r[4];
  assign out_ch.r12      = r_r[5];
  assign out_ch.r20      = r_r[6];
  assign out_ch.r21      = r_r[7];
  assign out_ch.r22      = r_r[8];
  assign out_ch.det_out  = det_r;
  assign out_ch.singular = sing_r;

endmodule
`default_nettype wire

>>> rtl/mi3_checker.sv
// ---------------------------------------------------------------------------
// mi3_checker
// Port-level checks for the 3x3 inverse, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mi3_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] r00,
  input wire logic [31:0] r11,
  input wire logic [31:0] r22,
  input wire logic [31:0] det_out,
  input wire logic        singular
);
  `MI3_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `MI3_ASSERT_IMP(a_ready_free, clk, rst_n, !out_valid, in_ready)
  `MI3_ASSERT_IMP(a_sing_zero, clk, rst_n, out_valid && singular, (r00 == 0) && (r11 == 0) && (r22 == 0))
  `MI3_ASSERT_IMP(a_sing_det, clk, rst_n, out_valid && singular, det_out == 0)
endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .r00(out_ch.r00), .r11(out_ch.r11), .r22(out_ch.r22),
  .det_out(out_ch.det_out), .singular(out_ch.singular)
);
`default_nettype wire
